// ----- design/rbdq_pkg.sv -----
// rbdq_pkg: shared types and constants for the ring buffer deque core
// holds command codes, status codes, field widths and the per-cell control struct
// no dependencies
package rbdq_pkg;

    localparam int CmdW    = 2;
    localparam int StatusW = 2;
    localparam int OccW    = 5;
    localparam int CapW    = 5;

    typedef enum logic [CmdW-1:0] {
        CMD_PUSH_BACK  = 2'd0,
        CMD_PUSH_FRONT = 2'd1,
        CMD_POP_BACK   = 2'd2,
        CMD_POP_FRONT  = 2'd3
    } t_cmd;

    typedef enum logic [StatusW-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // one operation for the whole row of cells in a cycle
    typedef struct packed {
        logic clear;       // drop all contents
        logic shift_up;    // push at the front: every cell takes its lower neighbour
        logic shift_down;  // pop at the front: every cell takes its upper neighbour
        logic add_back;    // first empty cell takes the pushed value
        logic drop_back;   // last valid cell goes empty
    } t_cell_ctrl;

endpackage

// ----- design/rbdq_cell.sv -----
// rbdq_cell: one storage cell of the deque row
// holds one item and its valid bit, exchanges data with both neighbours
// depends on rbdq_pkg
module rbdq_cell
    import rbdq_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctrl            i_ctrl,
    input  logic [DATA_WIDTH-1:0] i_push_data,
    input  logic [DATA_WIDTH-1:0] i_lower_data,
    input  logic                  i_lower_valid,
    input  logic [DATA_WIDTH-1:0] i_upper_data,
    input  logic                  i_upper_valid,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_valid,
    output logic                  o_is_back
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  r_valid;
    logic                  n_valid;

    // this cell holds the back item when the one above is empty
    assign o_is_back = r_valid && !i_upper_valid;
    assign o_data    = r_data;
    assign o_valid   = r_valid;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctrl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctrl.shift_up) begin
            n_data  = i_lower_data;
            n_valid = i_lower_valid;
        end else if (i_ctrl.shift_down) begin
            n_data  = i_upper_data;
            n_valid = i_upper_valid;
        end else if (i_ctrl.add_back) begin
            if (!r_valid && i_lower_valid) begin
                n_data  = i_push_data;
                n_valid = 1'b1;
            end
        end else if (i_ctrl.drop_back) begin
            if (o_is_back) begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

// ----- design/ring_buffer_deque_core.sv -----
// ring_buffer_deque_core: double-ended queue built as a row of shifting cells
// top level: command decode, count and capacity, output register
// depends on rbdq_pkg and rbdq_cell
//
//  channel  direction  handshake                    payload (low bit first)
//  s_axis   in         s_axis_tvalid/s_axis_tready  cmd, push_value
//  m_axis   out        m_axis_tvalid/m_axis_tready  pop_value, status, occupancy
//  cfg      in         i_cfg_we                     capacity
//
// one transfer per cycle in and out while m_axis is not stalled: each command moves
// the whole cell row in one step; the output register shows the result next cycle
// a full output register that is not taken holds s_axis_tready low
// reset empties the row and sets capacity to 16 (or DEPTH if smaller)
// a capacity write empties the row by the next cycle
module ring_buffer_deque_core
    import rbdq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_cfg_we,
    input  logic [CapW-1:0]                              i_cfg_wdata,
    input  logic                                         s_axis_tvalid,
    output logic                                         s_axis_tready,
    // cmd[1:0], push_value, zero padding
    input  logic [((CmdW+DATA_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
    output logic                                         m_axis_tvalid,
    input  logic                                         m_axis_tready,
    // pop_value, status, occupancy, zero padding
    output logic [((DATA_WIDTH+StatusW+OccW+7)/8)*8-1:0] m_axis_tdata
);

    localparam int OutW     = ((DATA_WIDTH + StatusW + OccW + 7) / 8) * 8;
    localparam int MaxCap   = (1 << CapW) - 1;
    localparam int CapLimit = (DEPTH < MaxCap) ? DEPTH : MaxCap;
    localparam int CapReset = (DEPTH < 16) ? DEPTH : 16;
    // no more cells than the largest capacity can ever fill
    localparam int UsedCells = CapLimit;

    t_cmd                  w_cmd;
    logic [DATA_WIDTH-1:0] w_push_value;
    logic                  w_accept;

    logic [CapW-1:0]       r_cap;
    logic [OccW-1:0]       r_count;
    logic [OccW-1:0]       n_count;

    t_cell_ctrl            w_ctrl;
    logic [DATA_WIDTH-1:0] w_data [UsedCells];
    logic [UsedCells-1:0]  w_valid;
    logic [UsedCells-1:0]  w_is_back;
    logic [DATA_WIDTH-1:0] w_back_data;

    logic [DATA_WIDTH-1:0] n_pop;
    t_status               n_status;

    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_pop;
    t_status               r_out_status;
    logic [OccW-1:0]       r_out_occ;

    assign w_cmd        = t_cmd'(s_axis_tdata[CmdW-1:0]);
    assign w_push_value = s_axis_tdata[CmdW +: DATA_WIDTH];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // back item select: exactly one cell flags itself as back when not empty
    always_comb begin
        w_back_data = '0;
        for (int i = 0; i < UsedCells; i++) begin
            w_back_data = w_back_data | (w_is_back[i] ? w_data[i] : '0);
        end
    end

    always_comb begin
        w_ctrl       = '0;
        w_ctrl.clear = i_cfg_we;
        n_count      = r_count;
        n_pop        = '0;
        n_status     = ST_OK;
        if (w_accept) begin
            case (w_cmd)
                CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                    if (r_count >= r_cap) begin
                        n_status = ST_FULL;
                    end else begin
                        n_count = r_count + OccW'(1);
                        if (w_cmd == CMD_PUSH_BACK) begin
                            w_ctrl.add_back = 1'b1;
                        end else begin
                            w_ctrl.shift_up = 1'b1;
                        end
                    end
                end
                CMD_POP_BACK, CMD_POP_FRONT: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_count = r_count - OccW'(1);
                        if (w_cmd == CMD_POP_BACK) begin
                            w_ctrl.drop_back = 1'b1;
                            n_pop            = w_back_data;
                        end else begin
                            w_ctrl.shift_down = 1'b1;
                            n_pop             = w_data[0];
                        end
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    for (genvar i = 0; i < UsedCells; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_lo_data;
        logic                  w_lo_valid;
        logic [DATA_WIDTH-1:0] w_up_data;
        logic                  w_up_valid;

        // the front cell sees the pushed value as an always-valid lower neighbour
        if (i == 0) begin : g_front
            assign w_lo_data  = w_push_value;
            assign w_lo_valid = 1'b1;
        end else begin : g_inner_lo
            assign w_lo_data  = w_data[i-1];
            assign w_lo_valid = w_valid[i-1];
        end

        if (i == UsedCells - 1) begin : g_end
            assign w_up_data  = '0;
            assign w_up_valid = 1'b0;
        end else begin : g_inner_up
            assign w_up_data  = w_data[i+1];
            assign w_up_valid = w_valid[i+1];
        end

        rbdq_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_push_data  (w_push_value),
            .i_lower_data (w_lo_data),
            .i_lower_valid(w_lo_valid),
            .i_upper_data (w_up_data),
            .i_upper_valid(w_up_valid),
            .o_data       (w_data[i]),
            .o_valid      (w_valid[i]),
            .o_is_back    (w_is_back[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CapW'(CapReset);
            r_count <= '0;
        end else if (i_cfg_we) begin
            // zero acts as one, anything past the row acts as the row length
            if (i_cfg_wdata == '0) begin
                r_cap <= CapW'(1);
            end else if (i_cfg_wdata > CapW'(CapLimit)) begin
                r_cap <= CapW'(CapLimit);
            end else begin
                r_cap <= i_cfg_wdata;
            end
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_pop    <= n_pop;
            r_out_status <= n_status;
            r_out_occ    <= n_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OutW'({r_out_occ, r_out_status, r_out_pop});

    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("item count disagrees with valid cells");

    a_count_within_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("item count above capacity");

    a_cfg_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_count == '0) && (w_valid == '0))
        else $error("capacity write did not empty the row");

    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_cfg_we && (r_count == r_cap)
            && ((w_cmd == CMD_PUSH_BACK) || (w_cmd == CMD_PUSH_FRONT)))
        |=> (r_out_status == ST_FULL) && $stable(r_count))
        else $error("push into a full deque was not refused");

endmodule
